// ===== sv/rde_pkg.sv =====
// Shared constants and the radix clamp for the radix digit emitter.
// No dependencies; used by the top level.
package rde_pkg;

  // Register and digit field widths
  localparam int RADIX_W = 4;
  localparam int DIGIT_W = 4;

  // Legal radix range; out-of-range register values clamp to these
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

  // Map a raw register value onto the radix actually used
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (raw < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/rde_cmpsub.sv =====
// Shared compare/subtract unit: remainder minus an operand, with a borrow-based
// greater-or-equal flag. Stand-alone, no package use.
module rde_cmpsub #(
  parameter int VALUE_WIDTH = 32,
  parameter int OPND_WIDTH  = 36
) (
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [OPND_WIDTH-1:0]  b,
  output logic                   ge,
  output logic [VALUE_WIDTH-1:0] diff
);

  logic [OPND_WIDTH:0] full;

  // One extra bit on top catches the borrow
  assign full = (OPND_WIDTH + 1)'(a) - {1'b0, b};
  assign ge   = ~full[OPND_WIDTH];
  assign diff = full[VALUE_WIDTH-1:0];

endmodule

// ===== sv/rde_pow_mem.sv =====
// Power table: holds radix powers written during the search, read back
// one step lower for each digit. One write port, one registered read port.
module rde_pow_mem #(
  parameter int VALUE_WIDTH = 32,
  parameter int ADDR_W      = 5
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [VALUE_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/radix_digit_emitter.sv =====
// Radix digit emitter: one value in, its digits out most significant first.
// Sequence: load, then a power search up to the largest power that fits (its exponent is
// the index of the top digit), then for each digit compare/subtract steps on the shared
// unit followed by an output state that holds until out_ready is high.
// One value at a time: in_ready is high only when no digit is pending.
// Reset (rst, synchronous): returns to idle and sets the radix register to 2.
module radix_digit_emitter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rde_pkg::RADIX_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [VALUE_WIDTH-1:0]          value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rde_pkg::DIGIT_W-1:0]     digit,
  output logic                            last
);

  localparam int PW_W = VALUE_WIDTH + rde_pkg::RADIX_W;
  localparam int EW   = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DIGIT,
    S_OUT
  } state_t;

  state_t                      state;
  logic [rde_pkg::RADIX_W-1:0] radix;
  logic [VALUE_WIDTH-1:0]      rem;
  logic [VALUE_WIDTH-1:0]      pw;
  logic [PW_W-1:0]             pwr;
  logic [EW-1:0]               expo;
  logic [rde_pkg::DIGIT_W-1:0] dcnt;

  logic [rde_pkg::RADIX_W-1:0] r_eff;
  logic [PW_W-1:0]             pwr_next;
  logic [PW_W-1:0]             opnd;
  logic                        ge;
  logic [VALUE_WIDTH-1:0]      diff;
  logic [VALUE_WIDTH-1:0]      pw_below;
  logic                        more_fit;

  assign r_eff = rde_pkg::eff_radix(radix);

  // Next power candidate; only used when the current one fits, so the low bits suffice
  assign pwr_next = PW_W'(pwr[VALUE_WIDTH-1:0]) * PW_W'(r_eff);

  // Shared unit compares against pw*r while searching, pw while digit stepping
  assign opnd = (state == S_SEARCH) ? pwr : PW_W'(pw);

  rde_cmpsub #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OPND_WIDTH  (PW_W)
  ) u_cmpsub (
    .a    (rem),
    .b    (opnd),
    .ge   (ge),
    .diff (diff)
  );

  // Powers stored by exponent; the next lower one is read ahead
  rde_pow_mem #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (EW)
  ) u_pow_mem (
    .clk   (clk),
    .we    (state == S_SEARCH),
    .waddr (expo),
    .wdata (pw),
    .raddr (expo - EW'(1)),
    .rdata (pw_below)
  );

  // Digit may grow while below radix-1 and the power still fits
  assign more_fit = ((rde_pkg::DIGIT_W + 1)'(dcnt) + (rde_pkg::DIGIT_W + 1)'(1)
                     < (rde_pkg::DIGIT_W + 1)'(r_eff)) && ge;

  // Handshake and result fields
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digit     = dcnt;
  assign last      = (expo == '0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radix <= rde_pkg::RADIX_RESET;
    end else begin
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rem   <= value;
            pw    <= VALUE_WIDTH'(1);
            pwr   <= PW_W'(r_eff);
            expo  <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (ge) begin
            pw   <= pwr[VALUE_WIDTH-1:0];
            pwr  <= pwr_next;
            expo <= expo + EW'(1);
          end else begin
            dcnt  <= '0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (more_fit) begin
            rem  <= diff;
            dcnt <= dcnt + rde_pkg::DIGIT_W'(1);
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (expo == '0) begin
              state <= S_IDLE;
            end else begin
              pw    <= pw_below;
              expo  <= expo - EW'(1);
              dcnt  <= '0;
              state <= S_DIGIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
